// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared widths, codes and the result beat type of the timestamp qualifier.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TS_SEC_W = 32;
    localparam int NSEC_W   = 30;
    localparam int STALE_W  = 17;
    localparam int TRY_W    = 4;
    localparam int LIMIT_W  = 16;

    localparam logic [NSEC_W-1:0]  NSEC_LAST       = 30'd999999999;
    localparam logic [STALE_W-1:0] STALE_MAX       = '1;
    localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = 16'd50000;
    localparam logic [TRY_W-1:0]   TRY_LIMIT_RST   = 4'd10;

    typedef enum logic {
        MODE_INIT = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef enum logic {
        CFG_STALE_LIMIT = 1'b0,
        CFG_TRY_LIMIT   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TS_SEC_W-1:0] time_sec;
        logic [NSEC_W-1:0]   time_nsec;
        logic                from_system;
        logic                extrapolated;
        logic                disabled_now;
    } result_t;

endpackage

// ===== rtl/stq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_in_if
// Read and init request channel: valid/ready with one timestamp triple.
// ----------------------------------------------------------------------------
interface stq_in_if
    import stq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [TS_SEC_W-1:0] shared_sec;
    logic [NSEC_W-1:0]   shared_nsec;
    logic [TS_SEC_W-1:0] check_sec;
    logic [NSEC_W-1:0]   check_nsec;
    logic [TS_SEC_W-1:0] system_sec;
    logic [NSEC_W-1:0]   system_nsec;

    modport source (
        output valid, mode, shared_sec, shared_nsec, check_sec, check_nsec,
               system_sec, system_nsec,
        input  ready
    );

    modport sink (
        input  valid, mode, shared_sec, shared_nsec, check_sec, check_nsec,
               system_sec, system_nsec,
        output ready
    );
endinterface

// ===== rtl/stq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_out_if
// Qualified timestamp channel: valid/ready with the returned time and flags.
// ----------------------------------------------------------------------------
interface stq_out_if
    import stq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TS_SEC_W-1:0] time_sec;
    logic [NSEC_W-1:0]   time_nsec;
    logic                from_system;
    logic                extrapolated;
    logic                disabled_now;

    modport source (
        output valid, time_sec, time_nsec, from_system, extrapolated, disabled_now,
        input  ready
    );

    modport sink (
        input  valid, time_sec, time_nsec, from_system, extrapolated, disabled_now,
        output ready
    );
endinterface

// ===== rtl/shared_timestamp_qualifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_timestamp_qualifier
// Qualifies shared-source timestamps against the last returned time.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beat per request. mode 0 loads the last timestamp from the
//          system time and enables the shared source (no result beat);
//          mode 1 is one read attempt, giving zero or one result beat.
//   rsp  : result beats (time, from_system, extrapolated, disabled_now).
//   cfg  : cfg_we/cfg_index/cfg_data write stale_limit (0) or try_limit (1);
//          write only while no request is outstanding.
// A result is registered: it goes to the result register, or to the skid register while an earlier result waits.
// Throughput: one request per cycle while req.ready is high; all qualification is one pass of
//   compare, increment and counter logic ahead of the result register.
// A two-entry output (result register plus skid register) keeps req open
//   while one result waits; req.ready drops only when both entries are full.
// Reset: shared source disabled, last timestamp and counters cleared,
//   limits at 50000 and 10, no result pending.
// ----------------------------------------------------------------------------
module shared_timestamp_qualifier
    import stq_pkg::*;
#(
    parameter int SEC_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    stq_in_if.sink             req,
    stq_out_if.source          rsp
);

    logic [LIMIT_W-1:0]   stale_limit_reg;
    logic [TRY_W-1:0]     try_limit_reg;
    logic [SEC_WIDTH-1:0] last_sec_reg,    last_sec_next;
    logic [NSEC_W-1:0]    last_nsec_reg,   last_nsec_next;
    logic [STALE_W-1:0]   stale_count_reg, stale_count_next;
    logic [TRY_W-1:0]     retry_count_reg, retry_count_next;
    logic                 enabled_reg,     enabled_next;

    logic                 out_valid_reg,  skid_valid_reg;
    result_t              out_data_reg,   skid_data_reg;

    logic                 accept;
    logic                 pop;
    logic                 push;
    result_t              res_next;

    assign accept    = req.valid && req.ready;
    assign pop       = out_valid_reg && rsp.ready;
    assign req.ready = !skid_valid_reg;

    // Qualification of one request beat
    always_comb
    begin
        logic [SEC_WIDTH-1:0] sh_sec;
        logic [SEC_WIDTH-1:0] sy_sec;
        logic [SEC_WIDTH-1:0] inc_sec;
        logic [NSEC_W-1:0]    inc_nsec;
        logic [STALE_W-1:0]   stale_inc;
        logic [TRY_W-1:0]     retry_inc;
        logic [TRY_W-1:0]     lim;
        logic                 older;
        logic                 match;
        result_t              sys_res;

        sh_sec = SEC_WIDTH'(req.shared_sec);
        sy_sec = SEC_WIDTH'(req.system_sec);

        older = (sh_sec < last_sec_reg) ||
                ((sh_sec == last_sec_reg) && (req.shared_nsec < last_nsec_reg));
        match = (req.shared_sec == req.check_sec) && (req.shared_nsec == req.check_nsec);

        // One nanosecond on from the last timestamp, carry into seconds
        if (last_nsec_reg >= NSEC_LAST)
        begin
            inc_nsec = '0;
            inc_sec  = last_sec_reg + SEC_WIDTH'(1);
        end
        else
        begin
            inc_nsec = last_nsec_reg + NSEC_W'(1);
            inc_sec  = last_sec_reg;
        end

        stale_inc = (stale_count_reg == STALE_MAX) ? stale_count_reg
                                                   : stale_count_reg + STALE_W'(1);
        retry_inc = retry_count_reg + TRY_W'(1);
        lim       = (try_limit_reg == '0) ? TRY_W'(1) : try_limit_reg;

        sys_res.time_sec     = req.system_sec;
        sys_res.time_nsec    = req.system_nsec;
        sys_res.from_system  = 1'b1;
        sys_res.extrapolated = 1'b0;
        sys_res.disabled_now = 1'b0;

        last_sec_next    = last_sec_reg;
        last_nsec_next   = last_nsec_reg;
        stale_count_next = stale_count_reg;
        retry_count_next = retry_count_reg;
        enabled_next     = enabled_reg;
        res_next         = sys_res;
        push             = 1'b0;

        if (accept)
        begin
            if (req.mode == MODE_INIT)
            begin
                last_sec_next    = sy_sec;
                last_nsec_next   = req.system_nsec;
                enabled_next     = 1'b1;
                retry_count_next = '0;
            end
            else if (!enabled_reg)
            begin
                push = 1'b1;
            end
            else if (older)
            begin
                push             = 1'b1;
                last_sec_next    = inc_sec;
                last_nsec_next   = inc_nsec;
                retry_count_next = '0;
                stale_count_next = stale_inc;
                if (stale_inc > STALE_W'(stale_limit_reg))
                begin
                    enabled_next          = 1'b0;
                    res_next.disabled_now = 1'b1;
                end
                else
                begin
                    res_next.time_sec     = inc_sec[TS_SEC_W-1:0];
                    res_next.time_nsec    = inc_nsec;
                    res_next.from_system  = 1'b0;
                    res_next.extrapolated = 1'b1;
                end
            end
            else if (match)
            begin
                push                 = 1'b1;
                last_sec_next        = sh_sec;
                last_nsec_next       = req.shared_nsec;
                stale_count_next     = '0;
                retry_count_next     = '0;
                res_next.time_sec    = req.shared_sec;
                res_next.time_nsec   = req.shared_nsec;
                res_next.from_system = 1'b0;
            end
            else if (retry_inc >= lim)
            begin
                // Out of retries: drop the shared source
                push                  = 1'b1;
                enabled_next          = 1'b0;
                retry_count_next      = '0;
                res_next.disabled_now = 1'b1;
            end
            else
            begin
                retry_count_next = retry_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg <= STALE_LIMIT_RST;
            try_limit_reg   <= TRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_STALE_LIMIT: stale_limit_reg <= cfg_data;
                CFG_TRY_LIMIT:   try_limit_reg   <= cfg_data[TRY_W-1:0];
                default:         stale_limit_reg <= stale_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sec_reg    <= '0;
            last_nsec_reg   <= '0;
            stale_count_reg <= '0;
            retry_count_reg <= '0;
            enabled_reg     <= 1'b0;
        end
        else
        begin
            last_sec_reg    <= last_sec_next;
            last_nsec_reg   <= last_nsec_next;
            stale_count_reg <= stale_count_next;
            retry_count_reg <= retry_count_next;
            enabled_reg     <= enabled_next;
        end
    end

    // Result register with skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res_next;
            end
            else
            begin
                out_data_reg <= res_next;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.time_sec     = out_data_reg.time_sec;
    assign rsp.time_nsec    = out_data_reg.time_nsec;
    assign rsp.from_system  = out_data_reg.from_system;
    assign rsp.extrapolated = out_data_reg.extrapolated;
    assign rsp.disabled_now = out_data_reg.disabled_now;

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    // A beat that reports a disable must leave the shared source off
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_next.disabled_now) |=> !enabled_reg)
        else $error("shared source still enabled after disable beat");

    // A result is never both a fallback and an extrapolation
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(res_next.from_system && res_next.extrapolated))
        else $error("fallback and extrapolated flags both set");

    // A disabled source only ever yields system time on reads
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == MODE_READ && !enabled_reg) |-> (push && res_next.from_system))
        else $error("read while disabled did not fall back to system time");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for shared_timestamp_qualifier. A short table of
// directed beats (disabled pass-through, nanosecond carry and seconds wrap,
// out-of-range nanoseconds, retry disable) is followed by a short stale run
// up to a stale disable and by random read/init traffic under several
// limit settings and idle patterns. Each result beat is compared against
// the row's pinned stamp where it has one, else an in-bench qualifier model.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    localparam int          STALL_LIMIT = 1000;
    localparam logic [31:0] SEC_TOP     = 32'hFFFF_FFFF;
    localparam logic [29:0] NSEC_TOP    = 30'h3FFF_FFFF;

    typedef struct packed {
        mode_t               mode;
        logic [TS_SEC_W-1:0] shared_sec;
        logic [NSEC_W-1:0]   shared_nsec;
        logic [TS_SEC_W-1:0] check_sec;
        logic [NSEC_W-1:0]   check_nsec;
        logic [TS_SEC_W-1:0] system_sec;
        logic [NSEC_W-1:0]   system_nsec;
    } stamp_req_t;

    typedef struct {
        stamp_req_t req;
        bit         pinned;
        result_t    pin;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    cfg_reg_t           cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    stq_in_if  req_bus ();
    stq_out_if rsp_bus ();

    shared_timestamp_qualifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // qualifier model state and limits
    logic [TS_SEC_W-1:0] ts_sec     = '0;
    logic [NSEC_W-1:0]   ts_nsec    = '0;
    logic [STALE_W-1:0]  stale_run  = '0;
    logic [TRY_W-1:0]    retry_run  = '0;
    logic                shared_on  = 1'b0;
    logic [LIMIT_W-1:0]  lim_stale  = STALE_LIMIT_RST;
    logic [TRY_W-1:0]    lim_try    = TRY_LIMIT_RST;

    result_t owed_stamps [$];
    row_t    plan [$];
    int      errors      = 0;
    int      idle_cycles = 0;
    int      src_idle    = 0;
    int      dst_stall   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t stamp(input logic [31:0] s, input logic [29:0] n,
                                      input logic sys, input logic ext, input logic dis);
        result_t r;
        r.time_sec     = s;
        r.time_nsec    = n;
        r.from_system  = sys;
        r.extrapolated = ext;
        r.disabled_now = dis;
        return r;
    endfunction

    function automatic stamp_req_t mk(input mode_t m,
                                      input logic [31:0] ss, input logic [29:0] sn,
                                      input logic [31:0] cs, input logic [29:0] cn,
                                      input logic [31:0] ys, input logic [29:0] yn);
        stamp_req_t r;
        r.mode        = m;
        r.shared_sec  = ss;
        r.shared_nsec = sn;
        r.check_sec   = cs;
        r.check_nsec  = cn;
        r.system_sec  = ys;
        r.system_nsec = yn;
        return r;
    endfunction

    // Advance the model by one request beat; returns 1 when a result is due.
    function automatic bit qualify(input stamp_req_t r, output result_t res);
        logic             older;
        logic [TRY_W-1:0] lim;
        res = '0;
        if (r.mode == MODE_INIT)
        begin
            ts_sec    = r.system_sec;
            ts_nsec   = r.system_nsec;
            shared_on = 1'b1;
            retry_run = '0;
            return 1'b0;
        end
        if (!shared_on)
        begin
            res = stamp(r.system_sec, r.system_nsec, 1'b1, 1'b0, 1'b0);
            return 1'b1;
        end
        older = (r.shared_sec < ts_sec) ||
                (r.shared_sec == ts_sec && r.shared_nsec < ts_nsec);
        if (older)
        begin
            if (ts_nsec >= NSEC_LAST)
            begin
                ts_nsec = '0;
                ts_sec  = ts_sec + 1'b1;
            end
            else
                ts_nsec = ts_nsec + 1'b1;
            retry_run = '0;
            if (stale_run != STALE_MAX)
                stale_run = stale_run + 1'b1;
            if (stale_run > {1'b0, lim_stale})
            begin
                shared_on = 1'b0;
                res = stamp(r.system_sec, r.system_nsec, 1'b1, 1'b0, 1'b1);
            end
            else
                res = stamp(ts_sec, ts_nsec, 1'b0, 1'b1, 1'b0);
            return 1'b1;
        end
        if (r.shared_sec == r.check_sec && r.shared_nsec == r.check_nsec)
        begin
            ts_sec    = r.shared_sec;
            ts_nsec   = r.shared_nsec;
            stale_run = '0;
            retry_run = '0;
            res = stamp(r.shared_sec, r.shared_nsec, 1'b0, 1'b0, 1'b0);
            return 1'b1;
        end
        lim       = (lim_try == '0) ? TRY_W'(1) : lim_try;
        retry_run = retry_run + 1'b1;
        if (retry_run >= lim)
        begin
            shared_on = 1'b0;
            retry_run = '0;
            res = stamp(r.system_sec, r.system_nsec, 1'b1, 1'b0, 1'b1);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [29:0] rand_nsec();
        if ($urandom_range(7) == 0)
            return 30'($urandom);
        return 30'($urandom_range(999999999));
    endfunction

    // Pick a shared time just older or just newer than the last timestamp.
    function automatic void near_stamp(input bit older, output logic [31:0] s,
                                       output logic [29:0] n);
        if ($urandom_range(1))
        begin
            s = ts_sec;
            n = older ? 30'(ts_nsec - 30'd1 - $urandom_range(1000))
                      : 30'(ts_nsec + $urandom_range(1000));
        end
        else
        begin
            s = older ? ts_sec - 1 - $urandom_range(3) : ts_sec + 1 + $urandom_range(3);
            n = rand_nsec();
        end
    endfunction

    function automatic stamp_req_t gen_item();
        stamp_req_t r;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(99);
        k    = $urandom_range(61);
        r = mk(MODE_READ, $urandom, rand_nsec(), $urandom, rand_nsec(),
               $urandom, rand_nsec());
        if (pick < 6)
        begin
            r.mode = MODE_INIT;
            if ($urandom_range(3) == 0)
            begin
                r.system_sec  = SEC_TOP - $urandom_range(1);
                r.system_nsec = 30'(NSEC_LAST - $urandom_range(2));
            end
        end
        else if (pick < 90)
        begin
            near_stamp(pick >= 50 && pick < 70, r.shared_sec, r.shared_nsec);
            {r.check_sec, r.check_nsec} = {r.shared_sec, r.shared_nsec};
            // corrupt the check copy in one bit, now and then replace it at random
            if (pick >= 70)
            begin
                if ($urandom_range(4) == 0)
                    {r.check_sec, r.check_nsec} = {$urandom, rand_nsec()};
                else
                    {r.check_sec, r.check_nsec} = {r.shared_sec, r.shared_nsec}
                                                  ^ (62'd1 << k);
            end
        end
        return r;
    endfunction

    task automatic add_row(input stamp_req_t r, input bit pinned, input result_t pin);
        row_t row;
        row.req    = r;
        row.pinned = pinned;
        row.pin    = pin;
        plan.push_back(row);
    endtask

    task automatic send(input stamp_req_t r, input bit pinned, input result_t pin);
        result_t res;
        bit      due;
        while ($urandom_range(99) < src_idle)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.mode        <= r.mode;
        req_bus.shared_sec  <= r.shared_sec;
        req_bus.shared_nsec <= r.shared_nsec;
        req_bus.check_sec   <= r.check_sec;
        req_bus.check_nsec  <= r.check_nsec;
        req_bus.system_sec  <= r.system_sec;
        req_bus.system_nsec <= r.system_nsec;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        due = qualify(r, res);
        if (pinned)
            owed_stamps.push_back(pin);
        else if (due)
            owed_stamps.push_back(res);
    endtask

    // Hold the request side until every owed beat is out, then let the
    // result register settle.
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (owed_stamps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t idx, input logic [LIMIT_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_STALE_LIMIT)
            lim_stale = val;
        else
            lim_try = val[TRY_W-1:0];
    endtask

    always @(posedge clk)
        rsp_bus.ready <= ($urandom_range(99) >= dst_stall);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = {rsp_bus.time_sec, rsp_bus.time_nsec, rsp_bus.from_system,
                   rsp_bus.extrapolated, rsp_bus.disabled_now};
            if (owed_stamps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, got sec=%0d nsec=%0d",
                         $time, got.time_sec, got.time_nsec);
            end
            else
            begin
                want = owed_stamps.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected sec=%0d nsec=%0d sys=%b ext=%b dis=%b",
                             $time, want.time_sec, want.time_nsec, want.from_system,
                             want.extrapolated, want.disabled_now);
                    $display("%0t: got      sec=%0d nsec=%0d sys=%b ext=%b dis=%b",
                             $time, got.time_sec, got.time_nsec, got.from_system,
                             got.extrapolated, got.disabled_now);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [LIMIT_W-1:0] st;
        logic [TRY_W-1:0]   tr;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_STALE_LIMIT;
        cfg_data            <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.mode        <= MODE_INIT;
        req_bus.shared_sec  <= '0;
        req_bus.shared_nsec <= '0;
        req_bus.check_sec   <= '0;
        req_bus.check_nsec  <= '0;
        req_bus.system_sec  <= '0;
        req_bus.system_nsec <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // source disabled out of reset: system time passes through
        add_row(mk(MODE_READ, 0, 0, 0, 0, SEC_TOP, NSEC_LAST), 1'b1,
                stamp(SEC_TOP, NSEC_LAST, 1'b1, 1'b0, 1'b0));
        add_row(mk(MODE_READ, SEC_TOP, NSEC_TOP, 0, 0, 0, 0), 1'b1,
                stamp(0, 0, 1'b1, 1'b0, 1'b0));
        add_row(mk(MODE_READ, 0, 0, 0, 0, SEC_TOP, NSEC_TOP), 1'b1,
                stamp(SEC_TOP, NSEC_TOP, 1'b1, 1'b0, 1'b0));
        // stale reads walk the last stamp across the seconds wrap
        add_row(mk(MODE_INIT, 0, 0, 0, 0, SEC_TOP, NSEC_LAST - 30'd1), 1'b0, '0);
        add_row(mk(MODE_READ, 0, 0, 0, 0, 123, 456), 1'b1,
                stamp(SEC_TOP, NSEC_LAST, 1'b0, 1'b1, 1'b0));
        add_row(mk(MODE_READ, 0, 0, 0, 0, 123, 456), 1'b1,
                stamp(0, 0, 1'b0, 1'b1, 1'b0));
        add_row(mk(MODE_READ, 0, 0, 0, 0, 7, 7), 1'b1, stamp(0, 0, 1'b0, 1'b0, 1'b0));
        // out-of-range nanoseconds are accepted as they are, and carry when stale
        add_row(mk(MODE_READ, SEC_TOP, NSEC_TOP, SEC_TOP, NSEC_TOP, 7, 7), 1'b1,
                stamp(SEC_TOP, NSEC_TOP, 1'b0, 1'b0, 1'b0));
        add_row(mk(MODE_READ, SEC_TOP, NSEC_TOP - 30'd1, SEC_TOP, NSEC_TOP - 30'd1, 7, 7),
                1'b1, stamp(0, 0, 1'b0, 1'b1, 1'b0));
        // seconds decide before nanoseconds
        add_row(mk(MODE_INIT, 0, 0, 0, 0, 100, 500), 1'b0, '0);
        add_row(mk(MODE_READ, 99, NSEC_LAST, 99, NSEC_LAST, 1, 1), 1'b0, '0);
        add_row(mk(MODE_READ, 101, 0, 101, 0, 1, 1), 1'b0, '0);
        // a match clears the retries seen so far
        add_row(mk(MODE_READ, 101, 0, 101, 1, 1, 1), 1'b0, '0);
        add_row(mk(MODE_READ, 102, 7, 103, 7, 1, 1), 1'b0, '0);
        add_row(mk(MODE_READ, 102, 7, 102, 7, 1, 1), 1'b0, '0);
        for (int i = 0; i < 9; i++)
            add_row(mk(MODE_READ, 200, 0, 200 ^ (i[0] << 31),
                       i[0] ? 30'd0 : 30'h2000_0000, 1, 1), 1'b0, '0);
        add_row(mk(MODE_READ, 200, 0, 201, 0, 5, NSEC_LAST), 1'b1,
                stamp(5, NSEC_LAST, 1'b1, 1'b0, 1'b1));
        add_row(mk(MODE_READ, 300, 0, 300, 0, 6, 1), 1'b1, stamp(6, 1, 1'b1, 1'b0, 1'b0));
        foreach (plan[i])
            send(plan[i].req, plan[i].pinned, plan[i].pin);

        // run stale at a low limit until the source disables
        write_cfg(CFG_STALE_LIMIT, 16'd4);
        send(mk(MODE_INIT, 0, 0, 0, 0, 1000, 0), 1'b0, '0);
        while (shared_on)
            send(mk(MODE_READ, 0, 0, 0, 0, $urandom, rand_nsec()), 1'b0, '0);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       begin st = 16'd0;     tr = 4'd1;  end
                1:       begin st = 16'hFFFF;  tr = 4'd15; end
                2:       begin st = 16'd3;     tr = 4'd0;  end
                3:       begin st = 16'd1;     tr = 4'd3;  end
                4:       begin st = 16'd2;     tr = 4'd2;  end
                5:       begin st = 16'd5;     tr = 4'd10; end
                6:       begin st = 16'd50000; tr = 4'd15; end
                default:
                begin
                    st = LIMIT_W'($urandom_range(8));
                    tr = TRY_W'($urandom_range(1, 15));
                end
            endcase
            write_cfg(CFG_STALE_LIMIT, st);
            write_cfg(CFG_TRY_LIMIT, LIMIT_W'(tr));
            case (ph / 2)
                0:       begin src_idle = 0;  dst_stall = 0;  end
                1:       begin src_idle = 45; dst_stall = 0;  end
                2:       begin src_idle = 0;  dst_stall = 45; end
                default: begin src_idle = 21; dst_stall = 21; end
            endcase
            repeat (220) send(gen_item(), 1'b0, '0);
        end

        req_bus.valid <= 1'b0;
        for (int w = 0; w < STALL_LIMIT && owed_stamps.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (owed_stamps.size() != 0)
            $display("%0t: %0d result beats never arrived", $time, owed_stamps.size());
        if (errors == 0 && owed_stamps.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stq_pkg.sv
rtl/stq_in_if.sv
rtl/stq_out_if.sv
rtl/shared_timestamp_qualifier.sv
tb/tb.sv
